// File: hdl/bts_pkg.sv
// Shared constants, types and codes for the bilinear texture sampler.
package bts_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int TEXEL_BITS = 16;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_BITS    = $clog2(MAX_DIM + 1);

   localparam int REG_BITS   = 9;
   localparam int COORD_BITS = 24;
   localparam int INDEX_BITS = 16;
   localparam int VALUE_BITS = 16;
   localparam int OUT_BITS   = 16;
   localparam int FRAC_BITS  = 16;
   localparam int WT_BITS    = FRAC_BITS + 1;
   localparam int ONE_Q16    = 65536;
   localparam int HALF_Q16   = 32768;

   localparam int PROD_BITS  = COORD_BITS + DIM_BITS + 1;
   localparam int FLOOR_BITS = PROD_BITS - FRAC_BITS;
   localparam int DIGIT_BITS = 4;
   localparam int DIV_STEPS  = (FLOOR_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int MAG_BITS   = DIV_STEPS * DIGIT_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);

   localparam int SAMP_BITS  = (TEXEL_BITS > OUT_BITS) ? TEXEL_BITS : OUT_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef logic [DIM_BITS-1:0]   dim_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [TEXEL_BITS-1:0] texel_type;
   typedef logic [FRAC_BITS-1:0]  frac_type;

   typedef struct packed {
      dim_type w;
      dim_type h;
   } dims_type;

   typedef struct packed {
      addr_type [3:0] addr;
      frac_type       fu;
      frac_type       fv;
   } taps_type;

endpackage

// File: hdl/bts_req_if.sv
// Request channel: texel writes and sample requests.
interface bts_req_if import bts_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic        [INDEX_BITS-1:0]  texel_index;
   logic        [VALUE_BITS-1:0]  texel_value;
   logic signed [COORD_BITS-1:0]  u_coord;
   logic signed [COORD_BITS-1:0]  v_coord;

   modport source (output valid, req_type, texel_index, texel_value, u_coord, v_coord,
                   input ready);
   modport sink   (input valid, req_type, texel_index, texel_value, u_coord, v_coord,
                   output ready);
endinterface

// File: hdl/bts_rsp_if.sv
// Response channel: blended sample values.
interface bts_rsp_if import bts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] sample_value;

   modport source (output valid, sample_value, input ready);
   modport sink   (input valid, sample_value, output ready);
endinterface

// File: hdl/bts_ram.sv
// Generic simple dual-port RAM with registered read.
module bts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/bts_csr.sv
// APB register block holding texture width and height.
module bts_csr import bts_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output dims_type                 dims
);

   logic [REG_BITS-1:0] width_ff, width_in;
   logic [REG_BITS-1:0] height_ff, height_in;
   logic                wr_en;
   logic                sel;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign sel    = paddr[CSR_ADDR_BITS-1];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      prdata    = '0;
      case (sel)
         CSR_IDX_WIDTH: begin
            prdata = CSR_DATA_BITS'(width_ff);
            if (wr_en) width_in = pwdata[REG_BITS-1:0];
         end
         CSR_IDX_HEIGHT: begin
            prdata = CSR_DATA_BITS'(height_ff);
            if (wr_en) height_in = pwdata[REG_BITS-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= REG_BITS'(1);
         height_ff <= REG_BITS'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero reads as one, oversize saturates
   always_comb begin
      if (width_ff == '0) dims.w = DIM_BITS'(1);
      else if (int'(width_ff) > MAX_WIDTH) dims.w = DIM_BITS'(MAX_WIDTH);
      else dims.w = DIM_BITS'(width_ff);
      if (height_ff == '0) dims.h = DIM_BITS'(1);
      else if (int'(height_ff) > MAX_HEIGHT) dims.h = DIM_BITS'(MAX_HEIGHT);
      else dims.h = DIM_BITS'(height_ff);
   end

endmodule

// File: hdl/bts_addr.sv
// Coordinate unit: scale, floor, repeat-wrap and texel addresses of the four taps.
module bts_addr import bts_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] u_coord,
   input  logic signed [COORD_BITS-1:0] v_coord,
   input  dims_type                     dims,
   output logic                         done,
   output taps_type                     taps
);

   localparam logic [2:0] A_IDLE  = 3'd0;
   localparam logic [2:0] A_MUL   = 3'd1;
   localparam logic [2:0] A_SPLIT = 3'd2;
   localparam logic [2:0] A_DIV   = 3'd3;
   localparam logic [2:0] A_FIX   = 3'd4;
   localparam logic [2:0] A_ROW   = 3'd5;
   localparam logic [2:0] A_ADDR  = 3'd6;

   function automatic dim_type rem_digit(dim_type rem, logic [DIGIT_BITS-1:0] digit,
                                         dim_type div);
      logic [DIM_BITS:0] t;
      dim_type           r;
      r = rem;
      for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
         t = {r, digit[k]};
         if (t >= {1'b0, div}) t = t - {1'b0, div};
         r = t[DIM_BITS-1:0];
      end
      return r;
   endfunction

   function automatic dim_type wrap_idx(logic neg, dim_type rem, dim_type n);
      dim_type r;
      r = (neg && rem != '0) ? n - rem : rem;
      return r;
   endfunction

   function automatic logic [MAG_BITS-1:0] floor_mag(logic [PROD_BITS-1:0] p);
      logic [FLOOR_BITS-1:0] fl;
      fl = p[PROD_BITS-1:FRAC_BITS];
      if (p[PROD_BITS-1]) fl = ~fl + 1'b1;
      return MAG_BITS'(fl);
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 done_ff, done_in;

   logic signed [COORD_BITS-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [PROD_BITS-1:0]  prod_u_ff, prod_u_in, prod_v_ff, prod_v_in;
   frac_type                     fu_ff, fu_in, fv_ff, fv_in;
   logic [MAG_BITS-1:0]          mag_u_ff, mag_u_in, mag_v_ff, mag_v_in;
   logic                         neg_u_ff, neg_u_in, neg_v_ff, neg_v_in;
   dim_type                      rem_u_ff, rem_u_in, rem_v_ff, rem_v_in;
   dim_type                      i0_ff, i0_in, i1_ff, i1_in, j0_ff, j0_in, j1_ff, j1_in;
   addr_type                     row0_ff, row0_in, row1_ff, row1_in;
   addr_type [3:0]               addr_ff, addr_in;

   logic [2*DIM_BITS-1:0] row0_full, row1_full;
   dim_type               i0_fix, j0_fix;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      u_in      = u_ff;
      v_in      = v_ff;
      prod_u_in = prod_u_ff;
      prod_v_in = prod_v_ff;
      fu_in     = fu_ff;
      fv_in     = fv_ff;
      mag_u_in  = mag_u_ff;
      mag_v_in  = mag_v_ff;
      neg_u_in  = neg_u_ff;
      neg_v_in  = neg_v_ff;
      rem_u_in  = rem_u_ff;
      rem_v_in  = rem_v_ff;
      i0_in     = i0_ff;
      i1_in     = i1_ff;
      j0_in     = j0_ff;
      j1_in     = j1_ff;
      row0_in   = row0_ff;
      row1_in   = row1_ff;
      addr_in   = addr_ff;
      i0_fix    = wrap_idx(neg_u_ff, rem_u_ff, dims.w);
      j0_fix    = wrap_idx(neg_v_ff, rem_v_ff, dims.h);
      row0_full = j0_ff * dims.w;
      row1_full = j1_ff * dims.w;

      case (state_ff)
         A_IDLE: begin
            if (start) begin
               u_in     = u_coord;
               v_in     = v_coord;
               state_in = A_MUL;
            end
         end
         A_MUL: begin
            prod_u_in = $signed(u_ff) * $signed({1'b0, dims.w})
                      + $signed(PROD_BITS'(HALF_Q16));
            prod_v_in = $signed(v_ff) * $signed({1'b0, dims.h})
                      + $signed(PROD_BITS'(HALF_Q16));
            state_in  = A_SPLIT;
         end
         A_SPLIT: begin
            fu_in    = prod_u_ff[FRAC_BITS-1:0];
            fv_in    = prod_v_ff[FRAC_BITS-1:0];
            neg_u_in = prod_u_ff[PROD_BITS-1];
            neg_v_in = prod_v_ff[PROD_BITS-1];
            mag_u_in = floor_mag(prod_u_ff);
            mag_v_in = floor_mag(prod_v_ff);
            rem_u_in = '0;
            rem_v_in = '0;
            step_in  = '0;
            state_in = A_DIV;
         end
         A_DIV: begin
            // magnitude of floor mod size, one digit per cycle
            rem_u_in = rem_digit(rem_u_ff, mag_u_ff[MAG_BITS-1 -: DIGIT_BITS], dims.w);
            rem_v_in = rem_digit(rem_v_ff, mag_v_ff[MAG_BITS-1 -: DIGIT_BITS], dims.h);
            mag_u_in = mag_u_ff << DIGIT_BITS;
            mag_v_in = mag_v_ff << DIGIT_BITS;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) state_in = A_FIX;
         end
         A_FIX: begin
            i0_in    = i0_fix;
            j0_in    = j0_fix;
            i1_in    = (i0_fix + 1'b1 >= dims.w) ? '0 : i0_fix + 1'b1;
            j1_in    = (j0_fix + 1'b1 >= dims.h) ? '0 : j0_fix + 1'b1;
            state_in = A_ROW;
         end
         A_ROW: begin
            row0_in  = row0_full[ADDR_BITS-1:0];
            row1_in  = row1_full[ADDR_BITS-1:0];
            state_in = A_ADDR;
         end
         A_ADDR: begin
            addr_in[0] = row0_ff + ADDR_BITS'(i0_ff);
            addr_in[1] = row0_ff + ADDR_BITS'(i1_ff);
            addr_in[2] = row1_ff + ADDR_BITS'(i0_ff);
            addr_in[3] = row1_ff + ADDR_BITS'(i1_ff);
            done_in    = 1'b1;
            state_in   = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff      <= u_in;
      v_ff      <= v_in;
      prod_u_ff <= prod_u_in;
      prod_v_ff <= prod_v_in;
      fu_ff     <= fu_in;
      fv_ff     <= fv_in;
      mag_u_ff  <= mag_u_in;
      mag_v_ff  <= mag_v_in;
      neg_u_ff  <= neg_u_in;
      neg_v_ff  <= neg_v_in;
      rem_u_ff  <= rem_u_in;
      rem_v_ff  <= rem_v_in;
      i0_ff     <= i0_in;
      i1_ff     <= i1_in;
      j0_ff     <= j0_in;
      j1_ff     <= j1_in;
      row0_ff   <= row0_in;
      row1_ff   <= row1_in;
      addr_ff   <= addr_in;
   end

   assign done      = done_ff;
   assign taps.addr = addr_ff;
   assign taps.fu   = fu_ff;
   assign taps.fv   = fv_ff;

endmodule

// File: hdl/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler.
//
// Request channel (req_chan, valid/ready): req_type selects a texel write
// (texel_index, texel_value) or a bilinear sample (u_coord, v_coord, signed
// Q8.16). Writes go straight into the single texel RAM, one beat a cycle
// while the block is idle. A sample gives one response beat
// (rsp_chan.sample_value, unsigned Q8.8). Texture width and height are set
// over the APB port (width at 0x0, height at 0x4); the user must set them
// only while no sample is in flight, which the block does not enforce.
// A sample is accepted only when the block is idle; it passes through the
// scaling multiply, the repeat-wrap remainder unit, the four tap reads
// through the one RAM read port and the two-level blend multiply. The block
// returns to idle, ready for the next beat, as its result becomes valid.
// The result sits in an output register, so further texel writes and the
// next sample's address work go on while the receiver stalls; a finished
// blend waits only if the previous result has not yet been taken.
// Reset is synchronous: width and height return to 1, the response channel
// empties. The texel RAM is not cleared and must be written before use.
module bilinear_texture_sampler import bts_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   bts_req_if.sink                  req_chan,
   bts_rsp_if.source                rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CALC = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_MULA = 3'd3;
   localparam logic [2:0] S_SUMA = 3'd4;
   localparam logic [2:0] S_MULB = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   localparam int P_BITS   = SAMP_BITS + WT_BITS;
   localparam int ROW_BITS = SAMP_BITS + FRAC_BITS;
   localparam int Q_BITS   = ROW_BITS + WT_BITS;
   localparam int SUM_BITS = SAMP_BITS + 2 * FRAC_BITS;

   dims_type  dims;
   taps_type  taps;
   logic      addr_done;
   logic      addr_start;
   logic      accept;
   logic      ram_we;
   addr_type  ram_raddr;
   texel_type ram_rdata;
   logic      out_free;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    rd_cnt_ff, rd_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] sample_ff, sample_in;

   texel_type [3:0]          s_ff, s_in;
   logic [3:0][P_BITS-1:0]   p_ff, p_in;
   logic [ROW_BITS-1:0]      top_ff, top_in, bot_ff, bot_in;
   logic [1:0][Q_BITS-1:0]   q_ff, q_in;

   logic [WT_BITS-1:0]   wu0, wu1, wv0, wv1;
   logic [1:0]           tap_sel;
   logic [SUM_BITS-1:0]  blend_sum;

   bts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .dims    (dims)
   );

   bts_addr u_addr (
      .clock   (clock),
      .reset   (reset),
      .start   (addr_start),
      .u_coord (req_chan.u_coord),
      .v_coord (req_chan.v_coord),
      .dims    (dims),
      .done    (addr_done),
      .taps    (taps)
   );

   bts_ram #(
      .WIDTH (TEXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_BITS'(req_chan.texel_index)),
      .wdata (TEXEL_BITS'(req_chan.texel_value)),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign ram_we         = accept && (req_chan.req_type == REQ_WRITE)
                           && (32'(req_chan.texel_index) < STORE_DEPTH);
   assign addr_start     = accept && (req_chan.req_type == REQ_SAMPLE);
   assign ram_raddr      = taps.addr[rd_cnt_ff[1:0]];
   assign tap_sel        = 2'(rd_cnt_ff - 1'b1);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign wu1 = WT_BITS'(taps.fu);
   assign wu0 = WT_BITS'(ONE_Q16) - wu1;
   assign wv1 = WT_BITS'(taps.fv);
   assign wv0 = WT_BITS'(ONE_Q16) - wv1;
   assign blend_sum = SUM_BITS'(q_ff[0] + q_ff[1]);

   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sample_in    = sample_ff;
      s_in         = s_ff;
      p_in         = p_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      q_in         = q_ff;

      case (state_ff)
         S_IDLE: begin
            if (addr_start) state_in = S_CALC;
         end
         S_CALC: begin
            if (addr_done) begin
               rd_cnt_in = '0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            // read data arrives in the cycle after its address
            if (rd_cnt_ff != '0) s_in[tap_sel] = ram_rdata;
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == 3'd4) state_in = S_MULA;
         end
         S_MULA: begin
            p_in[0]  = SAMP_BITS'(s_ff[0]) * wu0;
            p_in[1]  = SAMP_BITS'(s_ff[1]) * wu1;
            p_in[2]  = SAMP_BITS'(s_ff[2]) * wu0;
            p_in[3]  = SAMP_BITS'(s_ff[3]) * wu1;
            state_in = S_SUMA;
         end
         S_SUMA: begin
            top_in   = ROW_BITS'(p_ff[0] + p_ff[1]);
            bot_in   = ROW_BITS'(p_ff[2] + p_ff[3]);
            state_in = S_MULB;
         end
         S_MULB: begin
            q_in[0]  = top_ff * wv0;
            q_in[1]  = bot_ff * wv1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               sample_in    = blend_sum[2*FRAC_BITS +: OUT_BITS];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      s_ff      <= s_in;
      p_ff      <= p_in;
      top_ff    <= top_in;
      bot_ff    <= bot_in;
      q_ff      <= q_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_value = sample_ff;

   assert property (@(posedge clock) disable iff (reset)
      addr_done |-> state_ff == S_CALC)
      else $error("address unit finished outside the wait state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_chan.ready)
      |=> (state_ff == S_DONE && $stable(sample_ff)))
      else $error("finished blend overwrote a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result beat raised without a finished blend");

endmodule
